@@ hw/rtl/modular_power_and_inverse_top_defines.svh @@
// Assertion macros for the modular power block checker.
// Expects clk and arst_n in the scope of use.
`ifndef MODULAR_POWER_AND_INVERSE_TOP_DEFINES_SVH
`define MODULAR_POWER_AND_INVERSE_TOP_DEFINES_SVH

// same-cycle implication
`define MPI_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpi check failed");

// next-cycle implication
`define MPI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpi check failed");

`endif

@@ hw/rtl/mpi_pkg.sv @@
// Package for the modular power block: widths, reset constant, command types.
// No dependencies.
`default_nettype none

package mpi_pkg;

	localparam int MOD_WIDTH    = 32;
	localparam int EXP_WIDTH    = 63;
	localparam int BASE_WIDTH   = 63;
	localparam int EXPIN_WIDTH  = 63;
	localparam int RESULT_WIDTH = 32;
	localparam int CFG_WIDTH    = 32;

	localparam int ENW     = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
	localparam int PROD_W  = 2 * MOD_WIDTH;
	localparam int DIV_RAW = (BASE_WIDTH > PROD_W) ? BASE_WIDTH : PROD_W;
	localparam int DIV_W   = DIV_RAW + (DIV_RAW % 2);
	localparam int STEPS   = DIV_W / 2;
	localparam int CNT_W   = $clog2(STEPS);

	localparam logic [CFG_WIDTH-1:0] MODULUS_RESET = 32'd1000000007;

	typedef struct packed {
		logic load;
		logic step;
		logic mul_acc;
		logic mul_sq;
		logic commit_acc;
		logic commit_sq;
	} mpi_cmd_t;

	typedef struct packed {
		logic mod_small;
		logic exp_zero;
		logic exp_lsb;
		logic red_last;
	} mpi_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/mpi_ctrl.sv @@
// Controller for the modular power block: square-and-multiply sequencing.
// Depends on mpi_pkg.
`default_nettype none

module mpi_ctrl import mpi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire mpi_status_t status,
	output mpi_cmd_t         cmd,
	output logic             busy,
	output logic             done
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RED  = 4'b0010,
		S_CHK  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   tgt_acc_q, tgt_acc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tgt_acc_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			tgt_acc_q <= tgt_acc_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		tgt_acc_d = tgt_acc_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					tgt_acc_d = 1'b0;
					state_d   = status.mod_small ? S_FIN : S_RED;
				end
			end
			S_RED: begin
				cmd.step = 1'b1;
				if (status.red_last) begin
					cmd.commit_acc = tgt_acc_q;
					cmd.commit_sq  = !tgt_acc_q;
					state_d        = S_CHK;
				end
			end
			S_CHK: begin
				if (status.exp_zero) begin
					state_d = S_FIN;
				end else if (status.exp_lsb) begin
					cmd.mul_acc = 1'b1;
					tgt_acc_d   = 1'b1;
					state_d     = S_RED;
				end else begin
					cmd.mul_sq = 1'b1;
					tgt_acc_d  = 1'b0;
					state_d    = S_RED;
				end
			end
			S_FIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FIN);

endmodule

`default_nettype wire

@@ hw/rtl/mpi_datapath.sv @@
// Datapath for the modular power block: operand registers, multiplier,
// two-bit-per-cycle shift-subtract reducer and modulus register. Depends on mpi_pkg.
`default_nettype none

module mpi_datapath import mpi_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mpi_cmd_t                cmd,
	output mpi_status_t                  status,
	input  wire logic                    opcode,
	input  wire logic [BASE_WIDTH-1:0]   base,
	input  wire logic [EXPIN_WIDTH-1:0]  exponent,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_WIDTH-1:0]    cfg_data,
	output logic      [RESULT_WIDTH-1:0] result
);

	logic [MOD_WIDTH-1:0] mod_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [MOD_WIDTH-1:0] sq_q;
	logic [MOD_WIDTH-1:0] rem_q;
	logic [DIV_W-1:0]     div_q;
	logic [ENW-1:0]       exp_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [MOD_WIDTH:0]   mod_ext;
	logic [MOD_WIDTH:0]   sh1, r1, sh2, r2;
	logic [MOD_WIDTH-1:0] rem_next;
	logic [MOD_WIDTH-1:0] mul_a;
	logic [PROD_W-1:0]    prod;
	logic [ENW-1:0]       exp_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MODULUS_RESET[MOD_WIDTH-1:0];
		end else if (cfg_we) begin
			mod_q <= cfg_data[MOD_WIDTH-1:0];
		end
	end

	assign mod_ext = {1'b0, mod_q};
	assign sh1     = {rem_q, div_q[DIV_W-1]};
	assign r1      = (sh1 >= mod_ext) ? (sh1 - mod_ext) : sh1;
	assign sh2     = {r1[MOD_WIDTH-1:0], div_q[DIV_W-2]};
	assign r2      = (sh2 >= mod_ext) ? (sh2 - mod_ext) : sh2;
	assign rem_next = r2[MOD_WIDTH-1:0];

	assign mul_a = cmd.mul_sq ? sq_q : acc_q;
	assign prod  = PROD_W'(mul_a) * PROD_W'(sq_q);

	assign exp_load = opcode ? ENW'(mod_q - MOD_WIDTH'(2))
	                         : ENW'(exponent[EXP_WIDTH-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q <= DIV_W'(base);
			rem_q <= '0;
			cnt_q <= '0;
			acc_q <= (mod_q < MOD_WIDTH'(2)) ? '0 : MOD_WIDTH'(1);
			exp_q <= exp_load;
		end else if (cmd.mul_acc || cmd.mul_sq) begin
			div_q <= DIV_W'(prod);
			rem_q <= '0;
			cnt_q <= '0;
			if (cmd.mul_sq) begin
				exp_q <= exp_q >> 1;
			end
		end else if (cmd.step) begin
			div_q <= div_q << 2;
			rem_q <= rem_next;
			cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.commit_acc) begin
				acc_q    <= rem_next;
				exp_q[0] <= 1'b0;
			end
			if (cmd.commit_sq) begin
				sq_q <= rem_next;
			end
		end
	end

	assign status.mod_small = (mod_q < MOD_WIDTH'(2));
	assign status.exp_zero  = (exp_q == '0);
	assign status.exp_lsb   = exp_q[0];
	assign status.red_last  = (cnt_q == CNT_W'(STEPS - 1));

	assign result = RESULT_WIDTH'(acc_q);

endmodule

`default_nettype wire

@@ hw/rtl/modular_power_and_inverse_top.sv @@
// Top level of the modular power / Fermat inverse block.
// Depends on mpi_pkg, mpi_ctrl, mpi_datapath.
//
// channel   signals                        transaction
// command   start, busy, opcode/base/exp   start high while busy low
// config    cfg_we, cfg_data               cfg_we high
// result    done, result                   done high, one cycle
//
// One item at a time. A reduction is a load plus 32 two-bit steps. After the
// base is reduced, each set power bit adds a multiply into the accumulator and
// each shift of the power a squaring, each followed by a reduction. A modulus
// below 2 skips every reduction and goes straight to done. Run time is set by
// the shared shift-subtract reducer. No clearing pass after reset; the result
// cannot be stalled.
`default_nettype none

module modular_power_and_inverse_top import mpi_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    opcode,
	input  wire logic [BASE_WIDTH-1:0]   base,
	input  wire logic [EXPIN_WIDTH-1:0]  exponent,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_WIDTH-1:0]    cfg_data,
	output logic                         done,
	output logic      [RESULT_WIDTH-1:0] result
);

	mpi_cmd_t    cmd;
	mpi_status_t status;

	mpi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mpi_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.opcode   (opcode),
		.base     (base),
		.exponent (exponent),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule

`default_nettype wire

@@ hw/rtl/mpi_checker.sv @@
// Port-level checker for the modular power block, bound to the top level.
// Depends on modular_power_and_inverse_top_defines.svh.
`default_nettype none
`include "modular_power_and_inverse_top_defines.svh"

module mpi_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	`MPI_ASSERT_IMPL(a_done_busy, done, busy)
	`MPI_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`MPI_ASSERT_NEXT(a_done_idle, done, !busy && !done)
	`MPI_ASSERT_IMPL(a_fall_done, $fell(busy), $past(done))

endmodule

bind modular_power_and_inverse_top mpi_checker u_mpi_checker (.*);

`default_nettype wire
